// ===== design/hevd_pkg.sv =====
// Shared types and constants for the 2x2 Hessian eigen-decomposition pipeline.
// No dependencies; used by hessian_eigen_2x2.
package hevd_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int IN_W          = 32;
    localparam int EIG_W         = 34;
    localparam int INT_FRAC      = 30;
    localparam int PIPE_DEPTH    = 143;

    // per-beat bookkeeping that rides alongside the arithmetic
    typedef struct packed {
        logic        zero;
        logic        tneg;
        logic        rcneg;
        logic [31:0] rr;
        logic [31:0] cc;
        logic [31:0] rcm;
    } side_t;

endpackage

// ===== design/hevd_sqrt_cell.sv =====
// One digit cell of a pipelined restoring square root (one root bit per cell).
// No dependencies.
module hevd_sqrt_cell #(
    parameter int RW = 64,
    parameter int SW = 1
) (
    input  logic            clk,
    input  logic            ce,
    input  logic [RW-1:0]   rad_in,
    input  logic [RW/2+1:0] rem_in,
    input  logic [RW/2-1:0] root_in,
    input  logic [SW-1:0]   side_in,
    output logic [RW-1:0]   rad_out,
    output logic [RW/2+1:0] rem_out,
    output logic [RW/2-1:0] root_out,
    output logic [SW-1:0]   side_out
);

    localparam int QW = RW / 2;

    logic [QW+1:0] rem_sh;
    logic [QW+1:0] trial;
    logic [QW+1:0] diff;
    logic          take;
    logic [RW-1:0] rad_reg;
    logic [QW+1:0] rem_reg;
    logic [QW-1:0] root_reg;
    logic [SW-1:0] side_reg;

    assign rem_sh = {rem_in[QW-1:0], rad_in[RW-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign take   = (rem_sh >= trial);
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rad_reg  <= {rad_in[RW-3:0], 2'b00};
            rem_reg  <= take ? diff : rem_sh;
            root_reg <= {root_in[QW-2:0], take};
            side_reg <= side_in;
        end
    end

    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;

endmodule

// ===== design/hevd_div_cell.sv =====
// One digit cell of a pipelined restoring divider (one quotient bit per cell).
// No dependencies.
module hevd_div_cell #(
    parameter int DW = 33,
    parameter int QW = 31,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          ce,
    input  logic [QW-1:0] num_in,
    input  logic [DW-1:0] rem_in,
    input  logic [DW-1:0] den_in,
    input  logic [QW-1:0] quo_in,
    input  logic [SW-1:0] side_in,
    output logic [QW-1:0] num_out,
    output logic [DW-1:0] rem_out,
    output logic [DW-1:0] den_out,
    output logic [QW-1:0] quo_out,
    output logic [SW-1:0] side_out
);

    logic [DW:0]   rem_sh;
    logic [DW:0]   diff;
    logic          take;
    logic [QW-1:0] num_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [QW-1:0] quo_reg;
    logic [SW-1:0] side_reg;

    assign rem_sh = {rem_in, num_in[QW-1]};
    assign take   = (rem_sh >= {1'b0, den_in});
    assign diff   = rem_sh - {1'b0, den_in};

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            num_reg  <= {num_in[QW-2:0], 1'b0};
            rem_reg  <= take ? diff[DW-1:0] : rem_sh[DW-1:0];
            den_reg  <= den_in;
            quo_reg  <= {quo_in[QW-2:0], take};
            side_reg <= side_in;
        end
    end

    assign num_out  = num_reg;
    assign rem_out  = rem_reg;
    assign den_out  = den_reg;
    assign quo_out  = quo_reg;
    assign side_out = side_reg;

endmodule

// ===== design/hessian_eigen_2x2.sv =====
// Throughput: one beat per cycle unless stalled; the pipeline is a row of digit cells
// (two 32/31-cell square roots, two 31-cell dividers) plus a few arithmetic stages.
// The whole pipeline holds while an output beat waits to be taken.
// Reset (rst_n, async, active low) clears the valid bits and the output valid only.
// Depends on hevd_pkg, hevd_sqrt_cell, hevd_div_cell.
module hessian_eigen_2x2 #(
    parameter int FRAC_BITS = hevd_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // d_rr[31:0], d_rc[63:32], d_cc[95:64]
    output logic         m_tvalid,
    input  logic         m_tready,
    // eig_major, eig_minor, vec_a_x, vec_a_y, vec_b_x, vec_b_y, zero pad
    output logic [((2*hevd_pkg::EIG_W+4*(FRAC_BITS+2)+7)/8)*8-1:0] m_tdata
);

    localparam int VEC_W  = FRAC_BITS + 2;
    localparam int OUT_W  = 2 * hevd_pkg::EIG_W + 4 * VEC_W;
    localparam int OUT_PW = ((OUT_W + 7) / 8) * 8;
    localparam int VSH    = hevd_pkg::INT_FRAC - FRAC_BITS;
    localparam int SIDE_W = $bits(hevd_pkg::side_t);
    localparam int Q1_SW  = 64 + SIDE_W;
    localparam int T_SW   = 31 + SIDE_W;
    localparam int DEPTH  = hevd_pkg::PIPE_DEPTH;

    logic ce;
    logic [DEPTH-1:0] vld_reg;
    logic             m_tvalid_reg;
    logic [OUT_PW-1:0] m_tdata_reg;

    assign ce       = !m_tvalid_reg || m_tready;
    assign s_tready = ce;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else if (ce)
        begin
            vld_reg      <= {vld_reg[DEPTH-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[DEPTH-1];
        end
    end

    // ---------------- stage 0: difference and magnitudes
    logic [31:0] in_rr, in_rc, in_cc, in_rcm;
    logic [32:0] in_d;
    hevd_pkg::side_t in_side;
    logic [32:0] a0_reg, b0_reg;
    hevd_pkg::side_t s0_reg;

    assign in_rr  = s_tdata[31:0];
    assign in_rc  = s_tdata[63:32];
    assign in_cc  = s_tdata[95:64];
    assign in_d   = {in_cc[31], in_cc} - {in_rr[31], in_rr};
    assign in_rcm = in_rc[31] ? (32'd0 - in_rc) : in_rc;

    always_comb
    begin
        in_side       = '0;
        in_side.zero  = (in_rc == 32'd0);
        in_side.tneg  = (in_d != 33'd0) && (in_d[32] != in_rc[31]);
        in_side.rcneg = in_rc[31];
        in_side.rr    = in_rr;
        in_side.cc    = in_cc;
        in_side.rcm   = in_rcm;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            a0_reg <= in_d[32] ? (33'd0 - in_d) : in_d;
            b0_reg <= {in_rcm, 1'b0};
            s0_reg <= in_side;
        end
    end

    // ---------------- stage 1: scale down by one if either exceeds 2^31
    logic        big;
    logic        big1_reg;
    logic [31:0] a1_reg, b1_reg;
    hevd_pkg::side_t s1_reg;

    assign big = (a0_reg > 33'h0_8000_0000) || (b0_reg > 33'h0_8000_0000);

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            big1_reg <= big;
            a1_reg   <= big ? a0_reg[32:1] : a0_reg[31:0];
            b1_reg   <= big ? b0_reg[32:1] : b0_reg[31:0];
            s1_reg   <= s0_reg;
        end
    end

    // ---------------- normalize: shift left by 16, 8, 4, 2, 1 while both below 2^30
    logic [31:0]     na [0:5];
    logic [31:0]     nb [0:5];
    logic            nbig [0:5];
    hevd_pkg::side_t nside [0:5];

    assign na[0]    = a1_reg;
    assign nb[0]    = b1_reg;
    assign nbig[0]  = big1_reg;
    assign nside[0] = s1_reg;

    genvar k;
    generate
        for (k = 0; k < 5; k++)
        begin : g_norm
            localparam int SH = 16 >> k;
            logic            sh;
            logic [31:0]     a_reg, b_reg;
            logic            big_reg;
            hevd_pkg::side_t side_reg;

            assign sh = !nbig[k] && ((na[k] | nb[k]) < (32'd1 << (30 - SH)));

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    a_reg    <= sh ? (na[k] << SH) : na[k];
                    b_reg    <= sh ? (nb[k] << SH) : nb[k];
                    big_reg  <= nbig[k];
                    side_reg <= nside[k];
                end
            end

            assign na[k+1]    = a_reg;
            assign nb[k+1]    = b_reg;
            assign nbig[k+1]  = big_reg;
            assign nside[k+1] = side_reg;
        end
    endgenerate

    // ---------------- squares, then their sum
    logic [63:0] asq_reg, bsq_reg, rad1_reg;
    logic [31:0] am_reg, bm_reg, aa_reg, ba_reg;
    hevd_pkg::side_t sm_reg, sa_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            asq_reg  <= 64'(na[5]) * 64'(na[5]);
            bsq_reg  <= 64'(nb[5]) * 64'(nb[5]);
            am_reg   <= na[5];
            bm_reg   <= nb[5];
            sm_reg   <= nside[5];
            rad1_reg <= asq_reg + bsq_reg;
            aa_reg   <= am_reg;
            ba_reg   <= bm_reg;
            sa_reg   <= sm_reg;
        end
    end

    // ---------------- square root of a^2 + b^2
    logic [63:0]      q1_rad  [0:32];
    logic [33:0]      q1_rem  [0:32];
    logic [31:0]      q1_root [0:32];
    logic [Q1_SW-1:0] q1_side [0:32];

    assign q1_rad[0]  = rad1_reg;
    assign q1_rem[0]  = '0;
    assign q1_root[0] = '0;
    assign q1_side[0] = {aa_reg, ba_reg, sa_reg};

    genvar i;
    generate
        for (i = 0; i < 32; i++)
        begin : g_sq1
            hevd_sqrt_cell #(.RW(64), .SW(Q1_SW)) u_cell (
                .clk      (clk),
                .ce       (ce),
                .rad_in   (q1_rad[i]),
                .rem_in   (q1_rem[i]),
                .root_in  (q1_root[i]),
                .side_in  (q1_side[i]),
                .rad_out  (q1_rad[i+1]),
                .rem_out  (q1_rem[i+1]),
                .root_out (q1_root[i+1]),
                .side_out (q1_side[i+1])
            );
        end
    endgenerate

    // ---------------- denominator a + q, then rounded numerator b*2^30 + den/2
    logic [32:0] den_reg, dn_reg;
    logic [31:0] bd_reg;
    logic [61:0] num1_reg;
    hevd_pkg::side_t sd_reg, sn_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            den_reg  <= {1'b0, q1_side[32][Q1_SW-1 -: 32]} + {1'b0, q1_root[32]};
            bd_reg   <= q1_side[32][SIDE_W +: 32];
            sd_reg   <= q1_side[32][SIDE_W-1:0];
            num1_reg <= {bd_reg, 30'd0} + 62'(den_reg[32:1]);
            dn_reg   <= den_reg;
            sn_reg   <= sd_reg;
        end
    end

    // ---------------- |t| = num / den in Q.30
    logic [30:0]       d1_num  [0:31];
    logic [32:0]       d1_rem  [0:31];
    logic [32:0]       d1_den  [0:31];
    logic [30:0]       d1_quo  [0:31];
    logic [SIDE_W-1:0] d1_side [0:31];

    assign d1_num[0]  = num1_reg[30:0];
    assign d1_rem[0]  = 33'(num1_reg[61:31]);
    assign d1_den[0]  = dn_reg;
    assign d1_quo[0]  = '0;
    assign d1_side[0] = sn_reg;

    generate
        for (i = 0; i < 31; i++)
        begin : g_div1
            hevd_div_cell #(.DW(33), .QW(31), .SW(SIDE_W)) u_cell (
                .clk      (clk),
                .ce       (ce),
                .num_in   (d1_num[i]),
                .rem_in   (d1_rem[i]),
                .den_in   (d1_den[i]),
                .quo_in   (d1_quo[i]),
                .side_in  (d1_side[i]),
                .num_out  (d1_num[i+1]),
                .rem_out  (d1_rem[i+1]),
                .den_out  (d1_den[i+1]),
                .quo_out  (d1_quo[i+1]),
                .side_out (d1_side[i+1])
            );
        end
    endgenerate

    // ---------------- t^2 + 1.0
    logic [61:0] tsq_reg, rad2_reg;
    logic [30:0] tt_reg, tr_reg;
    hevd_pkg::side_t st_reg, sr_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            tsq_reg  <= 62'(d1_quo[31]) * 62'(d1_quo[31]);
            tt_reg   <= d1_quo[31];
            st_reg   <= d1_side[31];
            rad2_reg <= tsq_reg + (62'd1 << (2 * hevd_pkg::INT_FRAC));
            tr_reg   <= tt_reg;
            sr_reg   <= st_reg;
        end
    end

    logic [61:0]     q2_rad  [0:31];
    logic [32:0]     q2_rem  [0:31];
    logic [30:0]     q2_root [0:31];
    logic [T_SW-1:0] q2_side [0:31];

    assign q2_rad[0]  = rad2_reg;
    assign q2_rem[0]  = '0;
    assign q2_root[0] = '0;
    assign q2_side[0] = {tr_reg, sr_reg};

    generate
        for (i = 0; i < 31; i++)
        begin : g_sq2
            hevd_sqrt_cell #(.RW(62), .SW(T_SW)) u_cell (
                .clk      (clk),
                .ce       (ce),
                .rad_in   (q2_rad[i]),
                .rem_in   (q2_rem[i]),
                .root_in  (q2_root[i]),
                .side_in  (q2_side[i]),
                .rad_out  (q2_rad[i+1]),
                .rem_out  (q2_rem[i+1]),
                .root_out (q2_root[i+1]),
                .side_out (q2_side[i+1])
            );
        end
    endgenerate

    // ---------------- c = round(2^60 / sq)
    logic [60:0]     num2_reg;
    logic [30:0]     sq_reg;
    logic [T_SW-1:0] s2_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            num2_reg <= (61'd1 << (2 * hevd_pkg::INT_FRAC)) | 61'(q2_root[31][30:1]);
            sq_reg   <= q2_root[31];
            s2_reg   <= q2_side[31];
        end
    end

    logic [30:0]     d2_num  [0:31];
    logic [30:0]     d2_rem  [0:31];
    logic [30:0]     d2_den  [0:31];
    logic [30:0]     d2_quo  [0:31];
    logic [T_SW-1:0] d2_side [0:31];

    assign d2_num[0]  = num2_reg[30:0];
    assign d2_rem[0]  = 31'(num2_reg[60:31]);
    assign d2_den[0]  = sq_reg;
    assign d2_quo[0]  = '0;
    assign d2_side[0] = s2_reg;

    generate
        for (i = 0; i < 31; i++)
        begin : g_div2
            hevd_div_cell #(.DW(31), .QW(31), .SW(T_SW)) u_cell (
                .clk      (clk),
                .ce       (ce),
                .num_in   (d2_num[i]),
                .rem_in   (d2_rem[i]),
                .den_in   (d2_den[i]),
                .quo_in   (d2_quo[i]),
                .side_in  (d2_side[i]),
                .num_out  (d2_num[i+1]),
                .rem_out  (d2_rem[i+1]),
                .den_out  (d2_den[i+1]),
                .quo_out  (d2_quo[i+1]),
                .side_out (d2_side[i+1])
            );
        end
    endgenerate

    // ---------------- products t*c and t*|rc|, then rounding
    hevd_pkg::side_t sp_side;
    logic [30:0] sp_tm;
    logic [61:0] ps_reg;
    logic [62:0] pt_reg;
    logic [30:0] cp_reg, cr_reg, s_reg;
    logic [31:0] trc_reg;
    logic [61:0] ps_rnd;
    logic [62:0] pt_rnd;
    hevd_pkg::side_t sq_side_reg, sx_reg;

    assign sp_side = d2_side[31][SIDE_W-1:0];
    assign sp_tm   = d2_side[31][T_SW-1 -: 31];
    assign ps_rnd  = ps_reg + (62'd1 << (hevd_pkg::INT_FRAC - 1));
    assign pt_rnd  = pt_reg + (63'd1 << (hevd_pkg::INT_FRAC - 1));

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            ps_reg      <= 62'(sp_tm) * 62'(d2_quo[31]);
            pt_reg      <= 63'(sp_tm) * 63'(sp_side.rcm);
            cp_reg      <= d2_quo[31];
            sq_side_reg <= sp_side;
            s_reg       <= ps_rnd[60:30];
            trc_reg     <= pt_rnd[61:30];
            cr_reg      <= cp_reg;
            sx_reg      <= sq_side_reg;
        end
    end

    // ---------------- eigenvalues and vector components
    function automatic logic [VEC_W-1:0] to_vec(input logic [30:0] mag, input logic neg);
        logic [30:0]      sum;
        logic [VEC_W-1:0] r;
        sum = mag + (31'd1 << (VSH - 1));
        r   = VEC_W'(sum >> VSH);
        return neg ? (VEC_W'(0) - r) : r;
    endfunction

    logic [30:0] ce_c, ce_s;
    logic        ce_tn;
    logic [33:0] trs, ce_e1, ce_e2;
    logic [33:0] e1_reg, e2_reg, f1_reg, f2_reg, m1_reg, m2_reg;
    logic [VEC_W-1:0] n1_reg, n2_reg, mn2_reg, g1_reg, g2_reg, gm2_reg;

    assign ce_c  = sx_reg.zero ? (31'd1 << hevd_pkg::INT_FRAC) : cr_reg;
    assign ce_s  = sx_reg.zero ? 31'd0 : s_reg;
    assign ce_tn = sx_reg.zero ? 1'b0 : sx_reg.tneg;
    assign trs   = (sx_reg.tneg != sx_reg.rcneg) ? (34'd0 - {2'b00, trc_reg})
                                                 : {2'b00, trc_reg};
    assign ce_e1 = sx_reg.zero ? {{2{sx_reg.rr[31]}}, sx_reg.rr}
                               : {{2{sx_reg.rr[31]}}, sx_reg.rr} - trs;
    assign ce_e2 = sx_reg.zero ? {{2{sx_reg.cc[31]}}, sx_reg.cc}
                               : {{2{sx_reg.cc[31]}}, sx_reg.cc} + trs;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            e1_reg  <= ce_e1;
            e2_reg  <= ce_e2;
            n1_reg  <= to_vec(ce_c, 1'b0);
            n2_reg  <= to_vec(ce_s, !ce_tn);
            mn2_reg <= to_vec(ce_s, ce_tn);
            m1_reg  <= e1_reg[33] ? (34'd0 - e1_reg) : e1_reg;
            m2_reg  <= e2_reg[33] ? (34'd0 - e2_reg) : e2_reg;
            f1_reg  <= e1_reg;
            f2_reg  <= e2_reg;
            g1_reg  <= n1_reg;
            g2_reg  <= n2_reg;
            gm2_reg <= mn2_reg;
        end
    end

    // ---------------- order by magnitude; on a tie the smaller value leads
    logic first;

    assign first = (m1_reg > m2_reg) ||
                   ((m1_reg == m2_reg) && ($signed(f1_reg) < $signed(f2_reg)));

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            if (first)
            begin
                m_tdata_reg <= OUT_PW'({g1_reg, gm2_reg, g2_reg, g1_reg, f2_reg, f1_reg});
            end
            else
            begin
                m_tdata_reg <= OUT_PW'({g2_reg, g1_reg, g1_reg, gm2_reg, f1_reg, f2_reg});
            end
        end
    end

endmodule
